// ===== rtl/core/acrbs_pkg.sv =====
`default_nettype none
package acrbs_pkg;

    typedef logic [7:0] byte_t;

    function automatic byte_t sbox(input byte_t x);
        byte_t r;
        unique case (x)
            8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
            8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
            8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
            8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
            8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
            8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
            8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
            8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
            8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
            8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
            8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
            8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
            8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
            8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
            8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
            8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
            8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
            8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
            8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
            8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
            8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
            8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
            8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
            8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
            8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
            8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
            8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
            8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
            8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
            8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
            8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
            8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
            8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
            8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
            8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
            8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
            8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
            8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
            8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
            8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
            8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
            8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
            8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
            8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
            8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
            8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
            8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
            8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
            8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
            8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
            8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
            8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; default: r = 8'h16;
        endcase
        return r;
    endfunction

    function automatic byte_t gmul2(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // one column mix, bytes little-endian in the 32-bit word
    function automatic logic [31:0] mix_col(input logic [31:0] w);
        byte_t a0, a1, a2, a3, al;
        a0 = w[7:0]; a1 = w[15:8]; a2 = w[23:16]; a3 = w[31:24];
        al = a0 ^ a1 ^ a2 ^ a3;
        return {a3 ^ al ^ gmul2(a3 ^ a0), a2 ^ al ^ gmul2(a2 ^ a3),
                a1 ^ al ^ gmul2(a1 ^ a2), a0 ^ al ^ gmul2(a0 ^ a1)};
    endfunction

    localparam int unsigned REG_KEY_LOW  = 0;
    localparam int unsigned REG_KEY_HIGH = 1;
    localparam int unsigned REG_NONCE    = 2;
    localparam int unsigned REG_CTR      = 3;
    localparam int unsigned CFG_IDX_W    = 2;

endpackage
`default_nettype wire

// ===== rtl/core/acrbs_ram.sv =====
`default_nettype none
module acrbs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/acrbs_aes_core.sv =====
`default_nettype none
// iterative aes-128: one round per cycle with on-the-fly key schedule
module acrbs_aes_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [127:0] key,
    input  wire logic [127:0] blk_in,
    output logic              done,
    output logic [127:0]      blk_out
);
    logic [127:0] st_reg, st_next, rk_reg, rk_next, sb, sr, mc;
    logic [7:0]   rc_reg, rc_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next;
    logic [31:0]  tw;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb[8*i +: 8] = acrbs_pkg::sbox(st_reg[8*i +: 8]);
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                sr[8*(r+4*c) +: 8] = sb[8*(r + 4*((c + r) % 4)) +: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            mc[32*c +: 32] = acrbs_pkg::mix_col(sr[32*c +: 32]);
        end
        tw = {acrbs_pkg::sbox(rk_reg[103:96]), acrbs_pkg::sbox(rk_reg[127:120]),
              acrbs_pkg::sbox(rk_reg[119:112]), acrbs_pkg::sbox(rk_reg[111:104]) ^ rc_reg};
        rk_next[31:0]   = rk_reg[31:0] ^ tw;
        rk_next[63:32]  = rk_reg[63:32] ^ rk_next[31:0];
        rk_next[95:64]  = rk_reg[95:64] ^ rk_next[63:32];
        rk_next[127:96] = rk_reg[127:96] ^ rk_next[95:64];
        st_next  = ((rnd_reg == 4'd10) ? sr : mc) ^ rk_next;
        rc_next  = acrbs_pkg::gmul2(rc_reg);
        rnd_next = rnd_reg + 4'd1;
        busy_next = busy_reg && (rnd_reg != 4'd10);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            rnd_reg  <= 4'd1;
        end else if (start) begin
            busy_reg <= 1'b1;
            done     <= 1'b0;
            rnd_reg  <= 4'd1;
            st_reg   <= blk_in ^ key;
            rk_reg   <= key;
            rc_reg   <= 8'h01;
        end else if (busy_reg) begin
            busy_reg <= busy_next;
            done     <= !busy_next;
            rnd_reg  <= rnd_next;
            st_reg   <= st_next;
            rk_reg   <= rk_next;
            rc_reg   <= rc_next;
        end else begin
            done <= 1'b0;
        end
    end

    assign blk_out = st_reg;
endmodule
`default_nettype wire

// ===== rtl/core/aes_ctr_random_byte_stream_unit.sv =====
`default_nettype none
// a request is served from the cache, one byte read at a time, when it holds data;
// a zero count goes straight to the result; a refill, for each 16-byte block, starts
// the aes core, waits for its rounds and makes 16 one-byte cache writes
// one transaction at a time: a new request is taken only in the idle state
// reset: cache marked empty, counter offset, configuration and control registers cleared
module aes_ctr_random_byte_stream_unit #(
    parameter int unsigned CACHE_BYTES       = 64,
    parameter int unsigned MAX_REQUEST_BYTES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] byte_count
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] random_bytes
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);
    localparam int unsigned BLOCKS = CACHE_BYTES / 16;
    localparam int unsigned FILL   = BLOCKS * 16;
    localparam int unsigned AW     = $clog2(CACHE_BYTES);
    localparam int unsigned PW     = $clog2(FILL + 1);
    localparam int unsigned BW     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_FILL_GO, S_FILL_WAIT, S_FILL_WR, S_READ, S_READ_WAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [63:0] key_low_reg, key_high_reg, nonce_reg, ctr_start_reg, ctr_off_reg;
    logic [PW-1:0] pos_reg;
    logic [3:0]    need_reg, got_reg;
    logic [63:0]   acc_reg;
    logic [BW-1:0] blk_reg;
    logic [3:0]    wb_reg;          // byte index within a block being written
    logic          post_reg;        // refill started mid-request; the result follows it
    logic [127:0]  ks_reg;
    logic          aes_start, aes_done;
    logic [127:0]  aes_out;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;
    logic [3:0]    req_n;
    logic [AW+4:0] waddr_full;

    // configuration writes; the 2-bit index covers all four registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg <= '0; key_high_reg <= '0; nonce_reg <= '0; ctr_start_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                acrbs_pkg::CFG_IDX_W'(acrbs_pkg::REG_KEY_LOW):  key_low_reg   <= cfg_wdata;
                acrbs_pkg::CFG_IDX_W'(acrbs_pkg::REG_KEY_HIGH): key_high_reg  <= cfg_wdata;
                acrbs_pkg::CFG_IDX_W'(acrbs_pkg::REG_NONCE):    nonce_reg     <= cfg_wdata;
                acrbs_pkg::CFG_IDX_W'(acrbs_pkg::REG_CTR):      ctr_start_reg <= cfg_wdata;
            endcase
        end
    end

    // saturate the request size
    assign req_n = (s_tdata[3:0] > 4'(MAX_REQUEST_BYTES)) ? 4'(MAX_REQUEST_BYTES)
                                                           : s_tdata[3:0];

    acrbs_aes_core u_aes (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (aes_start),
        .key     ({key_high_reg, key_low_reg}),
        .blk_in  ({nonce_reg, ctr_start_reg + ctr_off_reg}),
        .done    (aes_done),
        .blk_out (aes_out)
    );

    assign waddr_full = (AW+5)'(blk_reg) * (AW+5)'(16) + (AW+5)'(wb_reg);
    assign ram_waddr  = waddr_full[AW-1:0];
    assign ram_we     = (state_reg == S_FILL_WR);
    assign ram_raddr  = pos_reg[AW-1:0];

    acrbs_ram #(.WIDTH(8), .DEPTH(CACHE_BYTES)) u_cache (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ks_reg[8*wb_reg +: 8]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign aes_start = (state_reg == S_FILL_GO);
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pos_reg     <= PW'(FILL);
            ctr_off_reg <= '0;
            blk_reg     <= '0;
            wb_reg      <= '0;
            post_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        need_reg <= req_n;
                        got_reg  <= '0;
                        acc_reg  <= '0;
                        if (req_n == 4'd0) begin
                            state_reg <= S_OUT;
                        end else if (pos_reg >= PW'(FILL)) begin
                            post_reg  <= 1'b0;
                            blk_reg   <= '0;
                            state_reg <= S_FILL_GO;
                        end else begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_FILL_GO: begin
                    state_reg <= S_FILL_WAIT;
                end
                S_FILL_WAIT: begin
                    if (aes_done) begin
                        ks_reg      <= aes_out;
                        ctr_off_reg <= ctr_off_reg + 64'd1;
                        wb_reg      <= '0;
                        state_reg   <= S_FILL_WR;
                    end
                end
                S_FILL_WR: begin
                    // one cache byte per cycle
                    wb_reg <= wb_reg + 4'd1;
                    if (wb_reg == 4'd15) begin
                        if (blk_reg == BW'(BLOCKS - 1)) begin
                            pos_reg   <= '0;
                            // last block: output if a mid-request refill found the request complete, else read on
                            state_reg <= (post_reg && got_reg == need_reg) ? S_OUT : S_READ;
                        end else begin
                            blk_reg   <= blk_reg + BW'(1);
                            state_reg <= S_FILL_GO;
                        end
                    end
                end
                S_READ: begin
                    // ram address is presented, data arrives next cycle
                    state_reg <= S_READ_WAIT;
                end
                S_READ_WAIT: begin
                    acc_reg[8*got_reg[2:0] +: 8] <= ram_rdata;
                    got_reg <= got_reg + 4'd1;
                    pos_reg <= pos_reg + PW'(1);
                    if (pos_reg + PW'(1) >= PW'(FILL)) begin
                        // drained: refill now, result after it
                        post_reg  <= 1'b1;
                        blk_reg   <= '0;
                        state_reg <= S_FILL_GO;
                    end else if (got_reg + 4'd1 == need_reg) begin
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_READ;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
